// ===== sv/vlr_pkg.sv =====
// Shared constants for the voxel line rasterizer.
`default_nettype none

package vlr_pkg;

  // Default coordinate width and fixed colour width.
  localparam int unsigned COORD_BITS_DEF = 6;
  localparam int unsigned COLOR_BITS     = 8;

  // Entries in the queue between the front and the walker.
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Codes for the driving axis.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

`default_nettype wire

// ===== sv/vlr_front.sv =====
// Front end: takes a line request apart into magnitudes, directions, axes and error seeds.
`default_nettype none

module vlr_front
  import vlr_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic [COORD_BITS-1:0]   start_x_i,
  input  wire logic [COORD_BITS-1:0]   start_y_i,
  input  wire logic [COORD_BITS-1:0]   start_z_i,
  input  wire logic [COORD_BITS-1:0]   end_x_i,
  input  wire logic [COORD_BITS-1:0]   end_y_i,
  input  wire logic [COORD_BITS-1:0]   end_z_i,
  output logic      [2:0]              neg_o,
  output logic      [COORD_BITS-1:0]   amaj_o,
  output logic      [COORD_BITS-1:0]   amin_a_o,
  output logic      [COORD_BITS-1:0]   amin_b_o,
  output logic      [1:0]              major_o,
  output logic signed [COORD_BITS+2:0] err_a_o,
  output logic signed [COORD_BITS+2:0] err_b_o
);

  logic [COORD_BITS-1:0] ax, ay, az;
  logic                  x_maj, y_maj;

  // Direction and magnitude of each axis delta.
  always_comb begin
    neg_o[0] = end_x_i < start_x_i;
    neg_o[1] = end_y_i < start_y_i;
    neg_o[2] = end_z_i < start_z_i;
    ax = neg_o[0] ? (start_x_i - end_x_i) : (end_x_i - start_x_i);
    ay = neg_o[1] ? (start_y_i - end_y_i) : (end_y_i - start_y_i);
    az = neg_o[2] ? (start_z_i - end_z_i) : (end_z_i - start_z_i);
  end

  // Driving axis: largest magnitude, ties going to x and then to y.
  always_comb begin
    x_maj = (ax >= ay) && (ax >= az);
    y_maj = !x_maj && (ay >= az);
    if (x_maj) begin
      major_o  = AXIS_X;
      amaj_o   = ax;
      amin_a_o = ay;
      amin_b_o = az;
    end else if (y_maj) begin
      major_o  = AXIS_Y;
      amaj_o   = ay;
      amin_a_o = ax;
      amin_b_o = az;
    end else begin
      major_o  = AXIS_Z;
      amaj_o   = az;
      amin_a_o = ay;
      amin_b_o = ax;
    end
  end

  // Initial error terms are twice the minor delta less the major delta.
  always_comb begin
    err_a_o = $signed({2'b00, amin_a_o, 1'b0}) - $signed({3'b000, amaj_o});
    err_b_o = $signed({2'b00, amin_b_o, 1'b0}) - $signed({3'b000, amaj_o});
  end

endmodule

`default_nettype wire

// ===== sv/vlr_queue.sv =====
// Small flip-flop queue that decouples the front end from the walker.
`default_nettype none

module vlr_queue
  import vlr_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/vlr_walk.sv =====
// Walker: steps queued lines one voxel per cycle unless a result is held.
`default_nettype none

module vlr_walk
  import vlr_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Job side
  input  wire logic                      job_valid_i,
  output logic                           job_pop_o,
  input  wire logic [COORD_BITS-1:0]     px_i,
  input  wire logic [COORD_BITS-1:0]     py_i,
  input  wire logic [COORD_BITS-1:0]     pz_i,
  input  wire logic [2:0]                neg_i,
  input  wire logic [COORD_BITS-1:0]     amaj_i,
  input  wire logic [COORD_BITS-1:0]     amin_a_i,
  input  wire logic [COORD_BITS-1:0]     amin_b_i,
  input  wire logic [1:0]                major_i,
  input  wire logic signed [COORD_BITS+2:0] err_a_i,
  input  wire logic signed [COORD_BITS+2:0] err_b_i,
  input  wire logic [COLOR_BITS-1:0]     color_i,
  // Result side
  output logic                           empty_o,
  input  wire logic                      pop_i,
  output logic [COORD_BITS-1:0]          voxel_x_o,
  output logic [COORD_BITS-1:0]          voxel_y_o,
  output logic [COORD_BITS-1:0]          voxel_z_o,
  output logic [COLOR_BITS-1:0]          voxel_color_o,
  output logic                           last_o
);

  localparam int unsigned ERR_W = COORD_BITS + 3;

  logic                    busy_q, busy_d;
  logic                    out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0]   px_q, py_q, pz_q, px_d, py_d, pz_d;
  logic [COORD_BITS-1:0]   rem_q, rem_d;
  logic signed [ERR_W-1:0] err_a_q, err_b_q, err_a_d, err_b_d;
  logic [2:0]              neg_q;
  logic [COORD_BITS-1:0]   amaj_q, amin_a_q, amin_b_q;
  logic [1:0]              major_q;
  logic [COLOR_BITS-1:0]   color_q;
  logic                    load, adv, at_end;
  logic                    step_a, step_b, step_x, step_y, step_z;
  logic signed [ERR_W-1:0] two_maj, two_min_a, two_min_b;

  assign load      = !busy_q && job_valid_i;
  assign adv       = busy_q && (!out_valid_q || pop_i);
  assign at_end    = rem_q == '0;
  assign job_pop_o = load;
  assign empty_o   = !out_valid_q;

  // Minor axes step when their error term is positive.
  always_comb begin
    step_a    = !err_a_q[ERR_W-1] && (err_a_q != '0);
    step_b    = !err_b_q[ERR_W-1] && (err_b_q != '0);
    two_maj   = $signed({2'b00, amaj_q, 1'b0});
    two_min_a = $signed({2'b00, amin_a_q, 1'b0});
    two_min_b = $signed({2'b00, amin_b_q, 1'b0});
    step_x    = (major_q == AXIS_X) || ((major_q == AXIS_Y) && step_a) ||
                ((major_q == AXIS_Z) && step_b);
    step_y    = (major_q == AXIS_Y) ||
                (((major_q == AXIS_X) || (major_q == AXIS_Z)) && step_a);
    step_z    = (major_q == AXIS_Z) ||
                (((major_q == AXIS_X) || (major_q == AXIS_Y)) && step_b);
  end

  // Next walk state: load a new job, or emit a voxel and advance, going idle after the last.
  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    rem_d       = rem_q;
    err_a_d     = err_a_q;
    err_b_d     = err_b_q;
    if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      busy_d  = 1'b1;
      px_d    = px_i;
      py_d    = py_i;
      pz_d    = pz_i;
      rem_d   = amaj_i;
      err_a_d = err_a_i;
      err_b_d = err_b_i;
    end else if (adv) begin
      out_valid_d = 1'b1;
      if (at_end) begin
        busy_d = 1'b0;
      end else begin
        rem_d   = rem_q - 1'b1;
        err_a_d = err_a_q + two_min_a - (step_a ? two_maj : '0);
        err_b_d = err_b_q + two_min_b - (step_b ? two_maj : '0);
        if (step_x) begin
          px_d = neg_q[0] ? px_q - 1'b1 : px_q + 1'b1;
        end
        if (step_y) begin
          py_d = neg_q[1] ? py_q - 1'b1 : py_q + 1'b1;
        end
        if (step_z) begin
          pz_d = neg_q[2] ? pz_q - 1'b1 : pz_q + 1'b1;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk datapath and the job held for the current line.
  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    pz_q    <= pz_d;
    rem_q   <= rem_d;
    err_a_q <= err_a_d;
    err_b_q <= err_b_d;
    if (load) begin
      neg_q    <= neg_i;
      amaj_q   <= amaj_i;
      amin_a_q <= amin_a_i;
      amin_b_q <= amin_b_i;
      major_q  <= major_i;
      color_q  <= color_i;
    end
  end

  // Result register, written with the voxel at the current position.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      voxel_x_o     <= px_q;
      voxel_y_o     <= py_q;
      voxel_z_o     <= pz_q;
      voxel_color_o <= color_q;
      last_o        <= at_end;
    end
  end

endmodule

`default_nettype wire

// ===== sv/voxel_line_rasterizer.sv =====
// Top level of the 3D line rasterizer: front end, job queue and walker.
//
//   Channel   Handshake          Payload
//   request   push / full        start_x_i start_y_i start_z_i end_x_i end_y_i end_z_i color_i
//   voxel     empty / pop        voxel_x_o voxel_y_o voxel_z_o voxel_color_o last_o
//
// A line with largest axis delta D gives D+1 voxels, one per cycle from the walker
// unless a held result stalls it. The walker loads each job in a step of its own and
// takes no new job until the last voxel is out, which sets the sustained request rate.
// Requests are classified in the cycle they are taken and wait in a two-entry queue.
// Reset empties the queue, idles the walker and marks the result register empty.
// A held result stalls only the walker; requests keep entering until the queue fills.
`default_nettype none

module voxel_line_rasterizer
  import vlr_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [COORD_BITS-1:0] start_x_i,
  input  wire logic [COORD_BITS-1:0] start_y_i,
  input  wire logic [COORD_BITS-1:0] start_z_i,
  input  wire logic [COORD_BITS-1:0] end_x_i,
  input  wire logic [COORD_BITS-1:0] end_y_i,
  input  wire logic [COORD_BITS-1:0] end_z_i,
  input  wire logic [COLOR_BITS-1:0] color_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [COORD_BITS-1:0]      voxel_x_o,
  output logic [COORD_BITS-1:0]      voxel_y_o,
  output logic [COORD_BITS-1:0]      voxel_z_o,
  output logic [COLOR_BITS-1:0]      voxel_color_o,
  output logic                       last_o
);

  localparam int unsigned ERR_W = COORD_BITS + 3;

  typedef struct packed {
    logic [COLOR_BITS-1:0]   color;
    logic signed [ERR_W-1:0] err_b;
    logic signed [ERR_W-1:0] err_a;
    logic [1:0]              major;
    logic [COORD_BITS-1:0]   amin_b;
    logic [COORD_BITS-1:0]   amin_a;
    logic [COORD_BITS-1:0]   amaj;
    logic [2:0]              neg;
    logic [COORD_BITS-1:0]   pz;
    logic [COORD_BITS-1:0]   py;
    logic [COORD_BITS-1:0]   px;
  } job_t;

  job_t wr_job, rd_job;
  logic q_full, q_empty, q_pop;

  // Classify the incoming request.
  vlr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .start_z_i (start_z_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .end_z_i   (end_z_i),
    .neg_o     (wr_job.neg),
    .amaj_o    (wr_job.amaj),
    .amin_a_o  (wr_job.amin_a),
    .amin_b_o  (wr_job.amin_b),
    .major_o   (wr_job.major),
    .err_a_o   (wr_job.err_a),
    .err_b_o   (wr_job.err_b)
  );

  assign wr_job.px    = start_x_i;
  assign wr_job.py    = start_y_i;
  assign wr_job.pz    = start_z_i;
  assign wr_job.color = color_i;
  assign full         = q_full;

  // Queue of classified jobs.
  vlr_queue #(
    .WIDTH($bits(job_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_job),
    .pop_i   (q_pop),
    .rdata_o (rd_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Walk each line out voxel by voxel.
  vlr_walk #(
    .COORD_BITS(COORD_BITS)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (!q_empty),
    .job_pop_o     (q_pop),
    .px_i          (rd_job.px),
    .py_i          (rd_job.py),
    .pz_i          (rd_job.pz),
    .neg_i         (rd_job.neg),
    .amaj_i        (rd_job.amaj),
    .amin_a_i      (rd_job.amin_a),
    .amin_b_i      (rd_job.amin_b),
    .major_i       (rd_job.major),
    .err_a_i       (rd_job.err_a),
    .err_b_i       (rd_job.err_b),
    .color_i       (rd_job.color),
    .empty_o       (empty),
    .pop_i         (pop),
    .voxel_x_o     (voxel_x_o),
    .voxel_y_o     (voxel_y_o),
    .voxel_z_o     (voxel_z_o),
    .voxel_color_o (voxel_color_o),
    .last_o        (last_o)
  );

`ifndef NO_ASSERTIONS
  // The walker takes a job only when the queue holds one.
  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("walker took a job from an empty queue");

  // A taken request is waiting in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !q_empty)
    else $error("accepted request missing from the queue");

  // The queue cannot be full and empty at once.
  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");
`endif

endmodule

`default_nettype wire
